[src/lmds_pkg.sv]
// Package for the LED matrix double-buffer scan unit.
// Holds the request opcodes, the request record and the digit glyph table.
// No dependencies.
`timescale 1ns / 1ps

package lmds_pkg;

    localparam int ROW_W      = 8;
    localparam int IDX_W      = 3;
    localparam int OP_W       = 3;
    localparam int DIGIT_W    = 4;
    localparam int GLYPH_ROWS = 5;
    localparam int GLYPH_W    = 3;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    typedef enum logic [OP_W-1:0] {
        OP_SET_ROW    = 3'd0,
        OP_SET_BIT    = 3'd1,
        OP_CLEAR      = 3'd2,
        OP_DRAW_DIGIT = 3'd3,
        OP_SWAP       = 3'd4,
        OP_SCAN       = 3'd5
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   column;
        logic [ROW_W-1:0]   row_bits;
        logic [DIGIT_W-1:0] digit;
    } req_t;

    typedef logic [GLYPH_W-1:0] glyph_t [GLYPH_ROWS];

    // glyph rows 0..4 for each digit; codes above nine carry a blank glyph
    localparam glyph_t GLYPH [16] = '{
        '{3'd7, 3'd5, 3'd5, 3'd5, 3'd7},
        '{3'd4, 3'd4, 3'd4, 3'd4, 3'd4},
        '{3'd7, 3'd1, 3'd7, 3'd4, 3'd7},
        '{3'd7, 3'd4, 3'd7, 3'd4, 3'd7},
        '{3'd4, 3'd4, 3'd7, 3'd5, 3'd5},
        '{3'd7, 3'd4, 3'd7, 3'd1, 3'd7},
        '{3'd7, 3'd5, 3'd7, 3'd1, 3'd7},
        '{3'd4, 3'd4, 3'd4, 3'd4, 3'd7},
        '{3'd7, 3'd5, 3'd7, 3'd5, 3'd7},
        '{3'd7, 3'd4, 3'd7, 3'd5, 3'd7},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
    };

endpackage

[src/led_matrix_double_buffer_scan_unit.sv]
// Top level of the LED matrix double-buffer scan unit.
// Two frame banks in flip-flops, edit logic and the scan word output register.
// Depends on lmds_pkg.
`timescale 1ns / 1ps

// One request is accepted every clock cycle unless intake is stopped. A request is
// held in the request register and is then executed by the per-row update logic
// of the frame banks; a scan tick places its word in the output register when it
// executes, so the word passes through the request register and then the output
// register. Intake stops only while a scan tick waits for a full output register
// that is not being taken. Both banks are flip-flops cleared by reset, so no
// clearing pass is needed. Rows at or above ROWS are not stored: edits to them
// are dropped and the scan counter wraps after row ROWS-1.
module led_matrix_double_buffer_scan_unit #(
    parameter int ROWS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [lmds_pkg::OP_W-1:0]       s_op,
    input  logic [lmds_pkg::IDX_W-1:0]      s_row,
    input  logic [lmds_pkg::IDX_W-1:0]      s_column,
    input  logic [lmds_pkg::ROW_W-1:0]      s_row_bits,
    input  logic [lmds_pkg::DIGIT_W-1:0]    s_digit,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lmds_pkg::ROW_W-1:0]      m_row_select,
    output logic [lmds_pkg::ROW_W-1:0]      m_row_data
);
    import lmds_pkg::*;

    localparam logic [IDX_W-1:0] ROW_LAST    = IDX_W'(ROWS - 1);
    localparam int               GLYPH_LIMIT = (ROWS < GLYPH_ROWS) ? ROWS : GLYPH_ROWS;

    typedef logic [ROW_W-1:0] bank_t [ROWS];

    req_t             req_reg;
    logic             req_valid_reg;
    bank_t            frame_reg  [2];
    bank_t            frame_next [2];
    logic             disp_reg, disp_next;
    logic             edit_bank;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic             m_valid_reg;
    logic [ROW_W-1:0] row_select_reg, row_select_next;
    logic [ROW_W-1:0] row_data_reg, row_data_next;
    logic             out_free;
    logic             is_scan;
    logic             exec_fire;
    logic             load_out;
    logic [ROW_W-1:0] glyph_bits;

    assign edit_bank = ~disp_reg;
    assign out_free  = ~m_valid_reg | m_ready;
    assign is_scan   = (op_t'(req_reg.op) == OP_SCAN);
    assign exec_fire = req_valid_reg & (~is_scan | out_free);
    assign load_out  = exec_fire & is_scan;
    assign s_ready   = ~req_valid_reg | exec_fire;

    assign m_valid      = m_valid_reg;
    assign m_row_select = row_select_reg;
    assign m_row_data   = row_data_reg;

    always_comb begin
        frame_next      = frame_reg;
        disp_next       = disp_reg;
        scan_next       = scan_reg;
        row_select_next = row_select_reg;
        row_data_next   = row_data_reg;
        glyph_bits      = '0;
        if (exec_fire) begin
            case (op_t'(req_reg.op))
                OP_SET_ROW: begin
                    for (int r = 0; r < ROWS; r++) begin
                        if (req_reg.row == IDX_W'(r)) begin
                            frame_next[edit_bank][r] = req_reg.row_bits;
                        end
                    end
                end
                OP_SET_BIT: begin
                    for (int r = 0; r < ROWS; r++) begin
                        if (req_reg.row == IDX_W'(r)) begin
                            frame_next[edit_bank][r] = frame_reg[edit_bank][r]
                                | (ROW_W'(1) << req_reg.column);
                        end
                    end
                end
                OP_CLEAR: begin
                    for (int r = 0; r < ROWS; r++) begin
                        frame_next[edit_bank][r] = '0;
                    end
                end
                OP_DRAW_DIGIT: begin
                    if (req_reg.digit <= DIGIT_MAX) begin
                        for (int i = 0; i < GLYPH_LIMIT; i++) begin
                            glyph_bits = ROW_W'(GLYPH[req_reg.digit][i]) << req_reg.column;
                            frame_next[edit_bank][i] = frame_reg[edit_bank][i] | glyph_bits;
                        end
                    end
                end
                OP_SWAP: begin
                    disp_next = ~disp_reg;
                end
                OP_SCAN: begin
                    row_select_next = ROW_W'(1) << scan_reg;
                    row_data_next   = '0;
                    for (int r = 0; r < ROWS; r++) begin
                        if (scan_reg == IDX_W'(r)) begin
                            row_data_next = frame_reg[disp_reg][r];
                        end
                    end
                    scan_next = (scan_reg == ROW_LAST) ? '0 : scan_reg + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            disp_reg      <= 1'b0;
            scan_reg      <= '0;
            for (int b = 0; b < 2; b++) begin
                for (int r = 0; r < ROWS; r++) begin
                    frame_reg[b][r] <= '0;
                end
            end
        end else begin
            if (s_ready) begin
                req_valid_reg <= s_valid;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            disp_reg  <= disp_next;
            scan_reg  <= scan_next;
            frame_reg <= frame_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            req_reg <= '{op: s_op, row: s_row, column: s_column,
                         row_bits: s_row_bits, digit: s_digit};
        end
        row_select_reg <= row_select_next;
        row_data_reg   <= row_data_next;
    end

    a_select_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> $onehot(row_select_reg))
        else $error("scan word row select is not one-hot");

    a_scan_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_valid_reg && row_select_reg == (ROW_W'(1) << $past(scan_reg)))
        else $error("scan request did not load the output register");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_reg <= ROW_LAST)
        else $error("scan row counter beyond last row");

    a_swap_toggles: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire && op_t'(req_reg.op) == OP_SWAP |=> disp_reg != $past(disp_reg))
        else $error("swap request did not exchange banks");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for led_matrix_double_buffer_scan_unit: drives edit, swap and
// scan requests with random gaps and output stalls, predicts every scan word and checks it.
// Depends on lmds_pkg and led_matrix_double_buffer_scan_unit.

module tb_top;
    import lmds_pkg::*;

    localparam int ROWS         = 8;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [ROW_W-1:0] row_sel;
        logic [ROW_W-1:0] row_data;
    } scan_word_t;

    logic                aclk       = 1'b0;
    logic                aresetn    = 1'b0;
    logic                s_valid    = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_op       = '0;
    logic [IDX_W-1:0]    s_row      = '0;
    logic [IDX_W-1:0]    s_column   = '0;
    logic [ROW_W-1:0]    s_row_bits = '0;
    logic [DIGIT_W-1:0]  s_digit    = '0;
    logic                m_valid;
    logic                m_ready    = 1'b0;
    logic [ROW_W-1:0]    m_row_select;
    logic [ROW_W-1:0]    m_row_data;

    led_matrix_double_buffer_scan_unit #(
        .ROWS(ROWS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_row       (s_row),
        .s_column    (s_column),
        .s_row_bits  (s_row_bits),
        .s_digit     (s_digit),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_row_select(m_row_select),
        .m_row_data  (m_row_data)
    );

    always #4 aclk = ~aclk;

    // frame model: entries 0..7 bank 0, 8..15 bank 1
    logic [ROW_W-1:0] frame_mem [16];
    logic             shown_bank    = 1'b0;
    logic [IDX_W-1:0] next_scan_row = '0;
    scan_word_t       expected_words [$];

    int  mismatches   = 0;
    int  cycle_count  = 0;
    int  request_count = 0;
    int  words_checked = 0;
    int  op_hits [8];
    bit  idle_on      = 1'b1;
    int  hold_cycles  = 0;

    initial begin
        foreach (frame_mem[i]) frame_mem[i] = '0;
        foreach (op_hits[i]) op_hits[i] = 0;
    end

    // packed as {row 4, row 3, row 2, row 1, row 0}
    function automatic logic [14:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        case (d)
            4'd0: return {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
            4'd1: return {3'd4, 3'd4, 3'd4, 3'd4, 3'd4};
            4'd2: return {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
            4'd3: return {3'd7, 3'd4, 3'd7, 3'd4, 3'd7};
            4'd4: return {3'd5, 3'd5, 3'd7, 3'd4, 3'd4};
            4'd5: return {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
            4'd6: return {3'd7, 3'd1, 3'd7, 3'd5, 3'd7};
            4'd7: return {3'd7, 3'd4, 3'd4, 3'd4, 3'd4};
            4'd8: return {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
            4'd9: return {3'd7, 3'd5, 3'd7, 3'd4, 3'd7};
            default: return '0;
        endcase
    endfunction

    task automatic apply_request(input req_t r);
        logic [ROW_W-1:0] glyph_row;
        logic [14:0]      glyph_word;
        scan_word_t       w;
        case (r.op)
            OP_SET_ROW: begin
                if (r.row < ROWS) frame_mem[{~shown_bank, r.row}] = r.row_bits;
            end
            OP_SET_BIT: begin
                if (r.row < ROWS)
                    frame_mem[{~shown_bank, r.row}] |= ROW_W'(1) << r.column;
            end
            OP_CLEAR: begin
                for (int i = 0; i < ROWS; i++) frame_mem[{~shown_bank, IDX_W'(i)}] = '0;
            end
            OP_DRAW_DIGIT: begin
                if (r.digit <= DIGIT_MAX) begin
                    glyph_word = digit_glyph(r.digit);
                    for (int i = 0; i < GLYPH_ROWS; i++) begin
                        glyph_row = ROW_W'(glyph_word[3*i +: 3]);
                        if (i < ROWS)
                            frame_mem[{~shown_bank, IDX_W'(i)}] |= glyph_row << r.column;
                    end
                end
            end
            OP_SWAP: begin
                shown_bank = ~shown_bank;
            end
            OP_SCAN: begin
                w.row_sel  = ROW_W'(1) << next_scan_row;
                w.row_data = frame_mem[{shown_bank, next_scan_row}];
                expected_words.push_back(w);
                next_scan_row = (next_scan_row == IDX_W'(ROWS - 1)) ? '0 : next_scan_row + 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [ROW_W-1:0] got,
                                   input logic [ROW_W-1:0] want);
        mismatches++;
        $display("[%0t] MISMATCH %s: got %02h, want %02h", $time, what, got, want);
    endtask

    function automatic req_t make_req(input logic [OP_W-1:0] op, input int row, input int column,
                                      input int row_bits, input int digit);
        req_t r;
        r.op       = op;
        r.row      = IDX_W'(row);
        r.column   = IDX_W'(column);
        r.row_bits = ROW_W'(row_bits);
        r.digit    = DIGIT_W'(digit);
        return r;
    endfunction

    function automatic req_t random_req(input int scan_pct);
        req_t r;
        int   pick;
        r.row      = IDX_W'($urandom_range(7));
        r.column   = IDX_W'($urandom_range(7));
        r.row_bits = ROW_W'($urandom_range(255));
        r.digit    = ($urandom_range(9) < 8) ? DIGIT_W'($urandom_range(9))
                                             : DIGIT_W'($urandom_range(15));
        if ($urandom_range(99) < scan_pct) begin
            r.op = OP_SCAN;
        end else begin
            pick = $urandom_range(69);
            if (pick < 20)      r.op = OP_SET_ROW;
            else if (pick < 35) r.op = OP_SET_BIT;
            else if (pick < 50) r.op = OP_DRAW_DIGIT;
            else if (pick < 58) r.op = OP_SWAP;
            else if (pick < 64) r.op = OP_CLEAR;
            else if (pick < 67) r.op = OP_UNUSED_6;
            else                r.op = OP_UNUSED_7;
        end
        return r;
    endfunction

    task automatic send_req(input req_t r);
        @(negedge aclk);
        while (idle_on && $urandom_range(99) < 7) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_op       = r.op;
        s_row      = r.row;
        s_column   = r.column;
        s_row_bits = r.row_bits;
        s_digit    = r.digit;
        do @(posedge aclk); while (!s_ready);
        apply_request(r);
        request_count++;
        op_hits[r.op]++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // receiver: random stalls, or a long hold-off when requested
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready = 1'b0;
            hold_cycles--;
        end else begin
            m_ready = !(idle_on && $urandom_range(99) < 7);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected scan word, row_select", m_row_select, '0);
            end else begin
                if (m_row_select !== expected_words[0].row_sel)
                    report_mismatch("row_select", m_row_select, expected_words[0].row_sel);
                if (m_row_data !== expected_words[0].row_data)
                    report_mismatch("row_data", m_row_data, expected_words[0].row_data);
                void'(expected_words.pop_front());
                words_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_edges();
        send_req(make_req(OP_SCAN, 0, 0, 0, 0));
        send_req(make_req(OP_SET_ROW, 0, 0, 8'hFF, 0));
        send_req(make_req(OP_SET_ROW, 7, 7, 8'h5A, 15));
        send_req(make_req(OP_SET_BIT, 3, 7, 8'h00, 0));
        send_req(make_req(OP_SET_BIT, 4, 0, 8'hFF, 0));
        send_req(make_req(OP_DRAW_DIGIT, 0, 7, 0, 9));
        send_req(make_req(OP_DRAW_DIGIT, 0, 0, 0, 15));
        send_req(make_req(OP_DRAW_DIGIT, 5, 3, 0, 10));
        send_req(make_req(OP_UNUSED_6, 7, 7, 8'hFF, 15));
        send_req(make_req(OP_UNUSED_7, 0, 0, 8'h00, 0));
        send_req(make_req(OP_SWAP, 0, 0, 0, 0));
        repeat (8) send_req(make_req(OP_SCAN, 0, 0, 0, 0));
        send_req(make_req(OP_SET_ROW, 2, 0, 8'hA5, 0));
        send_req(make_req(OP_CLEAR, 0, 0, 0, 0));
        send_req(make_req(OP_SWAP, 0, 0, 0, 0));
        repeat (2) send_req(make_req(OP_SCAN, 0, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_glyphs();
        for (int d = 0; d < 16; d++) begin
            send_req(make_req(OP_CLEAR, 0, 0, 0, 0));
            send_req(make_req(OP_DRAW_DIGIT, $urandom_range(7), $urandom_range(7), 0, d));
            send_req(make_req(OP_SWAP, 0, 0, 0, 0));
            repeat (8) send_req(make_req(OP_SCAN, 0, 0, 0, 0));
        end
        wait_drained();
    endtask

    task automatic test_output_stall();
        hold_cycles = 150;
        repeat (100) send_req(random_req(60));
        wait_drained();
    endtask

    task automatic test_random_burst();
        idle_on = 1'b0;
        repeat (200) send_req(random_req(30));
        wait_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        repeat (400) send_req(random_req(30));
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_edges();
        test_glyphs();
        test_output_stall();
        test_random_burst();
        test_random_traffic();

        $display("Covered %0d requests and %0d scan words in %0d cycles", request_count,
                 words_checked, cycle_count);
        $display("Op mix: set_row %0d, set_bit %0d, clear %0d, digit %0d, swap %0d, unused %0d",
                 op_hits[OP_SET_ROW], op_hits[OP_SET_BIT], op_hits[OP_CLEAR],
                 op_hits[OP_DRAW_DIGIT], op_hits[OP_SWAP],
                 op_hits[OP_UNUSED_6] + op_hits[OP_UNUSED_7]);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
src/lmds_pkg.sv
src/led_matrix_double_buffer_scan_unit.sv
verif/tb_top.sv
